@@ design/gbt_pkg.sv @@
// Shared types and constants for the Gaussian blur tap generator.
// No dependencies; used by gbt_div and gaussian_blur_tap_generator.
package gbt_pkg;

	localparam int DIV_W  = 64;   // dividend and quotient width
	localparam int DVS_W  = 32;   // divisor and remainder width
	localparam int CNT_W  = 7;    // iteration count, holds DIV_W
	localparam int FRAC   = 24;   // fraction bits of weights and offsets

	localparam logic [23:0] LN2_Q24  = 24'd11629080;
	localparam logic [3:0]  TERMS    = 4'd14;
	localparam logic [4:0]  K_LIMIT  = 5'd31;
	localparam logic [23:0] OUT_MAX  = 24'hFFFFFF;

	// quotient bits per division kind
	localparam logic [CNT_W-1:0] NB_EXPO = 7'd64;
	localparam logic [CNT_W-1:0] NB_WORD = 7'd32;
	localparam logic [CNT_W-1:0] NB_NORM = 7'd50;

	// request to the shared divider
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// answer of the shared divider
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

@@ design/gbt_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on gbt_pkg for the request and answer structs.
module gbt_div (
	input  logic             clk,
	input  logic             arst_n,
	input  gbt_pkg::div_req_t req,
	output gbt_pkg::div_rsp_t rsp
);
	import gbt_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;
	logic [CNT_W-1:0] pre_shift;

	// one compare and subtract per step
	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign pre_shift = NB_EXPO - req.nbits;

	// control: load, iterate, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out, quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend << pre_shift;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

@@ design/gbt_mul.sv @@
// Shared 32 x 32 multiplier with a registered product.
// No package dependency.
module gbt_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod_q
);

	// register the product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

@@ design/gaussian_blur_tap_generator.sv @@
// Top level: sequencer around the shared divider and multiplier.
// Depends on gbt_pkg, gbt_div and gbt_mul.
//
// Channel   Direction  Signals                                   Handshake
// command   in         start, busy, effect_factor                start & !busy
// taps      out        tap_valid, tap_index, tap_weight,         tap_valid, one cycle
//                      offset_horizontal, offset_vertical, last_tap
// config    in/out     psel, penable, pwrite, paddr, pwdata,     psel & penable & pready
//                      prdata, pready
//
// Each kernel tap of a run is dominated by the 14-term series, each term one pass
// through the one-bit-per-cycle divider.
// busy stays high for the run.
// Reset clears the sequencer and loads 1920 x 1080; the weight store is not cleared.
// Taps leave one per strobe with no back-pressure.
module gaussian_blur_tap_generator #(
	parameter int KERNEL_TAPS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] effect_factor,
	output logic        tap_valid,
	output logic [2:0]  tap_index,
	output logic [23:0] tap_weight,
	output logic [23:0] offset_horizontal,
	output logic [23:0] offset_vertical,
	output logic        last_tap,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gbt_pkg::*;

	localparam int XW    = $clog2(KERNEL_TAPS);
	localparam int PAIRS = ((KERNEL_TAPS - 1) / 2 > 4) ? 4 : (KERNEL_TAPS - 1) / 2;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_SQE  = 17'h00002,
		ST_SQS  = 17'h00004,
		ST_EXPA = 17'h00008,
		ST_EXPK = 17'h00010,
		ST_TMUL = 17'h00020,
		ST_TDIV = 17'h00040,
		ST_WSTO = 17'h00080,
		ST_RD0  = 17'h00100,
		ST_RD1  = 17'h00200,
		ST_RD2  = 17'h00400,
		ST_NRM0 = 17'h00800,
		ST_NRM1 = 17'h01000,
		ST_FRAC = 17'h02000,
		ST_OFFH = 17'h04000,
		ST_OFFV = 17'h08000,
		ST_EMIT = 17'h10000
	} state_t;

	state_t state_q;

	logic [13:0] width_q, height_q;
	logic        go_q;
	logic [15:0] e_q;
	logic [25:0] sigma_q;
	logic [27:0] s2_q;
	logic [31:0] a_q;
	logic [4:0]  kexp_q;
	logic [23:0] r_q;
	logic [30:0] term_q;
	logic [30:0] tp_q;
	logic signed [32:0] sum_q;
	logic [3:0]  n_q;
	logic [XW-1:0] xi_q;
	logic [31:0] total_q;
	logic [23:0] w0_q, wa_q, wb_q, rd_q;
	logic [2:0]  kt_q;
	logic [24:0] n0_q, n1_q, frac_q;
	logic [28:0] offh_q, offv_q;
	logic [23:0] mem_q [KERNEL_TAPS];

	logic        out_valid_q, out_last_q;
	logic [2:0]  out_idx_q;
	logic [23:0] out_wt_q, out_oh_q, out_ov_q;

	div_req_t    dreq;
	div_rsp_t    drsp;
	logic [31:0] mop_a, mop_b;
	logic [63:0] prod_q;

	logic [2*XW-1:0] xx;
	logic [3:0]      xa;
	logic [XW-1:0]   rd_addr;
	logic [30:0]     vclamp, vshift;
	logic [31:0]     wround;
	logic [23:0]     wnew;
	logic [24:0]     den;
	logic [27:0]     pix;
	logic [13:0]     wd, ht;
	logic [25:0]     wsum;
	logic [31:0]     half;

	gbt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	gbt_mul u_mul (.clk(clk), .op_a(mop_a), .op_b(mop_b), .prod_q(prod_q));

	// helper terms
	assign xx   = xi_q * xi_q;
	assign xa   = {kt_q, 1'b0} - 4'd1;
	assign den  = {1'b0, wa_q} + {1'b0, wb_q};
	assign pix  = {1'b0, xa[2:0], 24'b0} + {3'b0, frac_q};
	assign wd   = (width_q == '0) ? 14'd1 : width_q;
	assign ht   = (height_q == '0) ? 14'd1 : height_q;
	assign half = {1'b0, total_q[31:1]};
	assign wsum = {1'b0, n0_q} + {1'b0, n1_q};

	// clamp the series sum, scale by 2^-k, round to Q1.23
	always_comb begin
		if (sum_q[32])
			vclamp = '0;
		else if (sum_q > 33'sd1073741824)
			vclamp = 31'h40000000;
		else
			vclamp = sum_q[30:0];
		vshift = vclamp >> kexp_q;
		wround = ({1'b0, vshift} + 32'd64) >> 7;
		wnew   = (wround > {8'b0, OUT_MAX}) ? OUT_MAX : wround[23:0];
	end

	// multiplier operands
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		case (state_q)
			ST_SQE: begin
				mop_a = {16'b0, e_q};
				mop_b = {16'b0, e_q};
			end
			ST_SQS: begin
				mop_a = {6'b0, sigma_q};
				mop_b = {6'b0, sigma_q};
			end
			ST_TMUL: begin
				mop_a = {1'b0, term_q};
				mop_b = {8'b0, r_q};
			end
			default: ;
		endcase
	end

	// divider request
	always_comb begin
		dreq          = '0;
		dreq.start    = !go_q;
		dreq.nbits    = NB_WORD;
		case (state_q)
			ST_EXPA: begin
				dreq.nbits    = NB_EXPO;
				dreq.dividend = (DIV_W'(xx) << 48) + DIV_W'(s2_q);
				dreq.divisor  = {3'b0, s2_q, 1'b0};
			end
			ST_TDIV: begin
				dreq.dividend = DIV_W'(tp_q);
				dreq.divisor  = {28'b0, n_q};
			end
			ST_NRM0: begin
				dreq.nbits    = NB_NORM;
				dreq.dividend = {16'b0, wa_q, 24'b0} + DIV_W'(half);
				dreq.divisor  = total_q;
			end
			ST_NRM1: begin
				dreq.nbits    = NB_NORM;
				dreq.dividend = {16'b0, wb_q, 24'b0} + DIV_W'(half);
				dreq.divisor  = total_q;
			end
			ST_FRAC: begin
				dreq.start    = !go_q && (den != '0);
				dreq.nbits    = NB_NORM;
				dreq.dividend = {16'b0, wb_q, 24'b0} + DIV_W'(den >> 1);
				dreq.divisor  = DVS_W'(den);
			end
			ST_OFFH: begin
				dreq.dividend = DIV_W'(pix) + DIV_W'(wd >> 1);
				dreq.divisor  = DVS_W'(wd);
			end
			ST_OFFV: begin
				dreq.dividend = DIV_W'(pix) + DIV_W'(ht >> 1);
				dreq.divisor  = DVS_W'(ht);
			end
			default: dreq.start = 1'b0;
		endcase
	end

	// weight store read address
	always_comb begin
		case (state_q)
			ST_RD1:  rd_addr = XW'(xa + 4'd1);
			default: rd_addr = XW'(xa);
		endcase
	end

	// weight store
	always_ff @(posedge clk) begin
		if (state_q == ST_WSTO)
			mem_q[xi_q] <= wnew;
		rd_q <= mem_q[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd1920;
			height_q <= 14'd1080;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2])
				height_q <= pwdata[13:0];
			else
				width_q <= pwdata[13:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {18'b0, height_q} : {18'b0, width_q};

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_SQE;
				ST_SQE, ST_SQS, ST_TMUL: begin
					go_q <= !go_q;
					if (go_q) begin
						case (state_q)
							ST_SQE:  state_q <= ST_SQS;
							ST_SQS:  state_q <= ST_EXPA;
							default: state_q <= ST_TDIV;
						endcase
					end
				end
				ST_EXPK: begin
					// leave once the reduced exponent is below ln2 or the count saturates
					if (a_q < {8'b0, LN2_Q24} || kexp_q == K_LIMIT)
						state_q <= (kexp_q == K_LIMIT) ? ST_WSTO : ST_TMUL;
				end
				ST_EXPA, ST_TDIV, ST_NRM0, ST_NRM1, ST_OFFH, ST_OFFV: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (drsp.done) begin
						go_q <= 1'b0;
						case (state_q)
							ST_EXPA: state_q <= ST_EXPK;
							ST_TDIV: state_q <= (n_q == TERMS) ? ST_WSTO : ST_TMUL;
							ST_NRM0: state_q <= (kt_q == '0) ? ST_EMIT : ST_NRM1;
							ST_NRM1: state_q <= ST_FRAC;
							ST_OFFH: state_q <= ST_OFFV;
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_FRAC: begin
					if (den == '0) begin
						state_q <= ST_OFFH;
					end else if (!go_q) begin
						go_q <= 1'b1;
					end else if (drsp.done) begin
						go_q    <= 1'b0;
						state_q <= ST_OFFH;
					end
				end
				ST_WSTO: state_q <= (xi_q == XW'(KERNEL_TAPS - 1)) ? ST_NRM0 : ST_EXPA;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_NRM0;
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					state_q     <= (kt_q == 3'(PAIRS)) ? ST_IDLE : ST_RD0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: e_q <= effect_factor;
			ST_SQE:  sigma_q <= 26'd41943040 - 26'(prod_q[31:8]);
			ST_SQS: begin
				s2_q    <= 28'((prod_q[51:0] + 52'h800000) >> 24);
				xi_q    <= '0;
				total_q <= '0;
			end
			ST_EXPA: begin
				a_q    <= drsp.quot[31:0];
				kexp_q <= '0;
			end
			ST_EXPK: begin
				if (a_q >= {8'b0, LN2_Q24} && kexp_q != K_LIMIT) begin
					// strip one ln2 per cycle
					a_q    <= a_q - {8'b0, LN2_Q24};
					kexp_q <= kexp_q + 5'd1;
				end else begin
					// a large exponent underflows to a zero weight
					if (kexp_q == K_LIMIT) begin
						sum_q  <= '0;
						kexp_q <= '0;
					end else begin
						sum_q <= 33'sd1073741824;
					end
					r_q    <= a_q[23:0];
					term_q <= 31'h40000000;
					n_q    <= 4'd1;
				end
			end
			ST_TMUL: tp_q <= prod_q[54:24];
			ST_TDIV: begin
				if (drsp.done && go_q) begin
					term_q <= drsp.quot[30:0];
					if (n_q[0])
						sum_q <= sum_q - $signed({2'b0, drsp.quot[30:0]});
					else
						sum_q <= sum_q + $signed({2'b0, drsp.quot[30:0]});
					n_q <= n_q + 4'd1;
				end
			end
			ST_WSTO: begin
				if (xi_q == '0)
					w0_q <= wnew;
				if (xi_q == XW'(KERNEL_TAPS - 1)) begin
					// mirrored sum counts the centre once
					total_q <= ((total_q + 32'(wnew)) << 1) - 32'(w0_q);
					kt_q    <= '0;
					wa_q    <= w0_q;
				end else begin
					total_q <= total_q + 32'(wnew);
					xi_q    <= xi_q + 1'b1;
				end
			end
			ST_RD1: wa_q <= rd_q;
			ST_RD2: wb_q <= rd_q;
			ST_NRM0: n0_q <= drsp.quot[24:0];
			ST_NRM1: n1_q <= drsp.quot[24:0];
			ST_FRAC: frac_q <= (den == '0) ? 25'h800000 : drsp.quot[24:0];
			ST_OFFH: offh_q <= drsp.quot[28:0];
			ST_OFFV: offv_q <= drsp.quot[28:0];
			ST_EMIT: begin
				out_idx_q  <= kt_q;
				out_last_q <= (kt_q == 3'(PAIRS));
				if (kt_q == '0) begin
					out_wt_q <= (n0_q > 25'(OUT_MAX)) ? OUT_MAX : n0_q[23:0];
					out_oh_q <= '0;
					out_ov_q <= '0;
				end else begin
					out_wt_q <= (wsum > 26'(OUT_MAX)) ? OUT_MAX : wsum[23:0];
					out_oh_q <= (offh_q > 29'(OUT_MAX)) ? OUT_MAX : offh_q[23:0];
					out_ov_q <= (offv_q > 29'(OUT_MAX)) ? OUT_MAX : offv_q[23:0];
				end
				kt_q <= kt_q + 3'd1;
			end
			default: ;
		endcase
	end

	assign busy              = (state_q != ST_IDLE);
	assign tap_valid         = out_valid_q;
	assign tap_index         = out_idx_q;
	assign tap_weight        = out_wt_q;
	assign offset_horizontal = out_oh_q;
	assign offset_vertical   = out_ov_q;
	assign last_tap          = out_last_q;

`ifndef SYNTH
	// a run is busy from the accepted transfer on
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");

	// the final tap closes the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid && last_tap |-> !busy) else $error("busy after last tap");

	// taps never come back to back
	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid |=> !tap_valid) else $error("taps too close");

	// the centre tap carries no offset
	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		tap_valid && tap_index == 3'd0 |-> offset_horizontal == '0 &&
		offset_vertical == '0) else $error("centre tap offset");
`endif

endmodule
